@@ hw/rtl/ffsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsp_pkg
// Shared types and constants of the first-fit shape placer.
// ----------------------------------------------------------------------------
package ffsp_pkg;

	localparam int BOARD_MAX_DEF = 64;
	localparam int SHAPE_MAX_DEF = 16;
	localparam int ROW_W         = 16;
	localparam int DIM_W         = 5;
	localparam int CFG_W         = 7;
	localparam int QUEUE_DEPTH   = 2;
	localparam logic [CFG_W-1:0] BOARD_DIM_RESET = 7'd40;

	typedef enum logic [0:0] {
		REG_BOARD_ROWS = 1'b0,
		REG_BOARD_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRY,
		ST_ROT,
		ST_SCAN,
		ST_PICK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic        placed;
		logic [1:0]  rotation;
		logic [5:0]  top_row;
		logic [5:0]  left_col;
		logic [12:0] occupied_count;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ffsp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffsp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/ffsp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsp_queue
// Small request queue between the loading front and the placement back.
// ----------------------------------------------------------------------------
module ffsp_queue
	import ffsp_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic      [WIDTH-1:0] head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("request pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("request popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/ffsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsp_front
// Collects shape rows and, on the last row, forms one placement request.
// ----------------------------------------------------------------------------
module ffsp_front
	import ffsp_pkg::*;
#(
	parameter int SHAPE_MAX = SHAPE_MAX_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               take,
	input  wire logic [DIM_W-1:0]                   shape_rows,
	input  wire logic [DIM_W-1:0]                   shape_cols,
	input  wire logic [ROW_W-1:0]                   row_mask,
	input  wire logic                               last_row,
	output logic                                    push,
	output logic [2*DIM_W+SHAPE_MAX*ROW_W-1:0]      push_data
);

	localparam int SIW = (SHAPE_MAX > 1) ? $clog2(SHAPE_MAX) : 1;

	logic [ROW_W-1:0] store_q [SHAPE_MAX];
	logic [DIM_W-1:0] cnt_q;
	logic [DIM_W-1:0] h_c;
	logic [DIM_W-1:0] w_c;
	logic [ROW_W-1:0] wmask;
	logic [ROW_W-1:0] masked;
	logic             room;
	logic [DIM_W-1:0] held;

	always_comb begin
		h_c = (shape_rows > DIM_W'(SHAPE_MAX)) ? DIM_W'(SHAPE_MAX) : shape_rows;
		w_c = (shape_cols > DIM_W'(SHAPE_MAX)) ? DIM_W'(SHAPE_MAX) : shape_cols;
		wmask  = (w_c >= DIM_W'(ROW_W)) ? '1 : ((ROW_W'(1) << w_c) - ROW_W'(1));
		masked = row_mask & wmask;
		room   = (cnt_q < DIM_W'(SHAPE_MAX));
		held   = room ? cnt_q + DIM_W'(1) : cnt_q;
	end

	assign push = take && last_row;

	always_comb begin
		push_data = '0;
		push_data[2*DIM_W+SHAPE_MAX*ROW_W-1 -: DIM_W] = h_c;
		push_data[DIM_W+SHAPE_MAX*ROW_W-1 -: DIM_W]   = w_c;
		for (int i = 0; i < SHAPE_MAX; i++) begin
			if (DIM_W'(i) < h_c && DIM_W'(i) < held) begin
				push_data[i*ROW_W +: ROW_W] = (DIM_W'(i) == cnt_q) ? masked : store_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (last_row) begin
				cnt_q <= '0;
			end else if (room) begin
				cnt_q <= cnt_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && room) begin
			store_q[cnt_q[SIW-1:0]] <= masked;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ffsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsp_back
// Placement engine: rotates the shape, scans the occupancy RAM for the first
// free position, marks the placed cells and holds the result register.
// ----------------------------------------------------------------------------
module ffsp_back
	import ffsp_pkg::*;
#(
	parameter int BOARD_MAX = BOARD_MAX_DEF,
	parameter int SHAPE_MAX = SHAPE_MAX_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [CFG_W-1:0]                   br,
	input  wire logic [CFG_W-1:0]                   bc,
	input  wire logic                               job_valid,
	input  wire logic [2*DIM_W+SHAPE_MAX*ROW_W-1:0] job_data,
	output logic                                    job_pop,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output result_t                                 res
);

	localparam int AW  = (BOARD_MAX > 1) ? $clog2(BOARD_MAX) : 1;
	localparam int SIW = (SHAPE_MAX > 1) ? $clog2(SHAPE_MAX) : 1;
	localparam int XW  = BOARD_MAX + ROW_W;

	back_state_t state_q, state_d;

	logic [ROW_W-1:0]     cur_q [SHAPE_MAX];
	logic [ROW_W-1:0]     rot_row [SHAPE_MAX];
	logic [DIM_W-1:0]     r_q, c_q;
	logic [1:0]           rot_q;
	logic [CFG_W-1:0]     top_q;
	logic [CFG_W-1:0]     left_q;
	logic [DIM_W-1:0]     ri_q;
	logic [BOARD_MAX-1:0] bad_q;
	logic [BOARD_MAX-1:0] occ_vld_q;
	logic                 rd_pend_s1;
	logic                 vld_s1;
	logic [SIW-1:0]       rd_idx_s1;
	logic [12:0]          total_q;
	logic                 placed_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic [DIM_W-1:0]     job_h, job_w;
	logic                 fits_board, scan_done, any_free, next_top_ok, mark_last, out_free;
	logic                 issue_rd, ram_we;
	logic [CFG_W-1:0]     addr_full;
	logic [AW-1:0]        ram_addr;
	logic [BOARD_MAX-1:0] ram_rdata, rrow, conf, free_vec, wdata;
	logic [CFG_W-1:0]     first_free;
	logic [SIW-1:0]       sel_idx;
	logic [ROW_W-1:0]     srow;
	logic [XW-1:0]        ext_row, shp;
	logic [DIM_W-1:0]     pop_cnt;
	logic [DIM_W-1:0]     rot_shift;
	logic [SHAPE_MAX-1:0] full_row;

	assign job_h = job_data[2*DIM_W+SHAPE_MAX*ROW_W-1 -: DIM_W];
	assign job_w = job_data[DIM_W+SHAPE_MAX*ROW_W-1 -: DIM_W];

	always_comb begin
		fits_board  = ({2'b00, r_q} <= br) && ({2'b00, c_q} <= bc);
		scan_done   = (ri_q == r_q) && !rd_pend_s1;
		next_top_ok = ({1'b0, top_q} + {3'b000, r_q} + 8'd1) <= {1'b0, br};
		mark_last   = (ri_q == r_q - DIM_W'(1));
		out_free    = !out_valid_q || !res_stall;
		addr_full   = top_q + {2'b00, ri_q};
		ram_addr    = addr_full[AW-1:0];
		rrow        = vld_s1 ? ram_rdata : '0;
		sel_idx     = (state_q == ST_MARK_WR) ? ri_q[SIW-1:0] : rd_idx_s1;
		srow        = cur_q[sel_idx];
		ext_row     = {{ROW_W{1'b0}}, rrow};
		shp         = XW'(srow) << left_q;
		wdata       = rrow | shp[BOARD_MAX-1:0];
	end

	// One bit per candidate left column: the shape row would hit an occupied cell.
	always_comb begin
		for (int l = 0; l < BOARD_MAX; l++) begin
			conf[l] = |(ext_row[l +: ROW_W] & srow);
			free_vec[l] = !bad_q[l] &&
				(({1'b0, CFG_W'(l)} + {3'b000, c_q}) <= {1'b0, bc});
		end
	end

	always_comb begin
		any_free   = 1'b0;
		first_free = '0;
		for (int l = BOARD_MAX - 1; l >= 0; l--) begin
			if (free_vec[l]) begin
				any_free   = 1'b1;
				first_free = CFG_W'(l);
			end
		end
	end

	always_comb begin
		pop_cnt = '0;
		for (int b = 0; b < ROW_W; b++) begin
			pop_cnt = pop_cnt + DIM_W'(srow[b]);
		end
	end

	// A clockwise quarter turn is a vertical flip of the full square followed by a
	// transpose; the shift then pulls the r used rows back down to bit zero.
	always_comb begin
		rot_shift = DIM_W'(SHAPE_MAX) - r_q;
		for (int i = 0; i < SHAPE_MAX; i++) begin
			for (int j = 0; j < SHAPE_MAX; j++) begin
				full_row[j] = cur_q[SHAPE_MAX-1-j][i];
			end
			rot_row[i] = ROW_W'(full_row >> rot_shift);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = (job_h == '0 || job_w == '0) ? ST_DONE : ST_TRY;
				end
			end
			ST_TRY: begin
				if (fits_board) begin
					state_d = ST_SCAN;
				end else begin
					state_d = (rot_q == 2'd3) ? ST_DONE : ST_ROT;
				end
			end
			ST_ROT: state_d = ST_TRY;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (any_free) begin
					state_d = ST_MARK_RD;
				end else if (next_top_ok) begin
					state_d = ST_SCAN;
				end else begin
					state_d = (rot_q == 2'd3) ? ST_DONE : ST_ROT;
				end
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: state_d = mark_last ? ST_DONE : ST_MARK_RD;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = (state_q == ST_IDLE) && job_valid;
		issue_rd = (state_q == ST_SCAN) && (ri_q < r_q);
		ram_we   = (state_q == ST_MARK_WR);
	end

	ffsp_ram #(
		.WIDTH(BOARD_MAX),
		.DEPTH(BOARD_MAX)
	) u_occ_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(wdata),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_vld_q   <= '0;
			rd_pend_s1  <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= issue_rd;
			if (ram_we) begin
				occ_vld_q[ram_addr] <= 1'b1;
				total_q <= total_q + 13'(pop_cnt);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ri_q[SIW-1:0];
		vld_s1    <= occ_vld_q[ram_addr];
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					for (int i = 0; i < SHAPE_MAX; i++) begin
						cur_q[i] <= job_data[i*ROW_W +: ROW_W];
					end
					r_q      <= job_h;
					c_q      <= job_w;
					rot_q    <= 2'd0;
					placed_q <= 1'b0;
				end
			end
			ST_TRY: begin
				top_q <= '0;
				ri_q  <= '0;
				bad_q <= '0;
			end
			ST_ROT: begin
				for (int i = 0; i < SHAPE_MAX; i++) begin
					cur_q[i] <= rot_row[i];
				end
				r_q   <= c_q;
				c_q   <= r_q;
				rot_q <= rot_q + 2'd1;
			end
			ST_SCAN: begin
				if (issue_rd) begin
					ri_q <= ri_q + DIM_W'(1);
				end
				if (rd_pend_s1) begin
					bad_q <= bad_q | conf;
				end
			end
			ST_PICK: begin
				ri_q <= '0;
				if (any_free) begin
					left_q <= first_free;
				end else begin
					top_q <= top_q + CFG_W'(1);
					bad_q <= '0;
				end
			end
			ST_MARK_WR: begin
				ri_q <= ri_q + DIM_W'(1);
				if (mark_last) begin
					placed_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_q.placed         <= placed_q;
			out_q.rotation       <= placed_q ? rot_q : 2'd0;
			out_q.top_row        <= placed_q ? top_q[5:0] : 6'd0;
			out_q.left_col       <= placed_q ? left_q[5:0] : 6'd0;
			out_q.occupied_count <= total_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

`ifndef SYNTHESIS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (ri_q <= r_q))
		else $error("scan row index ran past shape height");
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MARK_WR) |=> (total_q == $past(total_q)))
		else $error("occupied count changed outside marking");
	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.placed) |->
		(out_q.rotation == 2'd0 && out_q.top_row == 6'd0 && out_q.left_col == 6'd0))
		else $error("dropped shape reports a position");
	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == ST_TRY || state_q == ST_DONE))
		else $error("request taken without starting a search");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/first_fit_shape_placer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_shape_placer
// First-fit placement of binary shapes, with rotation, on an occupancy board.
// ----------------------------------------------------------------------------
// Shape rows are taken one per cycle while the request queue has room; a row
// with last_row set closes the shape and queues a placement request. The
// search engine reads the board through one RAM read port: for each candidate
// top row it reads the r rows under the shape (r = rotated shape height) and
// checks all left columns at once; each quarter turn passes through a rotate
// and a retry state, and marking reads and then writes back each shape row. The
// board is clear right after reset, with no clearing pass, and stays as it is
// across writes of board_rows and board_cols.
// ----------------------------------------------------------------------------
module first_fit_shape_placer
	import ffsp_pkg::*;
#(
	parameter int BOARD_MAX = BOARD_MAX_DEF,
	parameter int SHAPE_MAX = SHAPE_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [DIM_W-1:0]   shape_rows,
	input  wire logic [DIM_W-1:0]   shape_cols,
	input  wire logic [ROW_W-1:0]   row_mask,
	input  wire logic               last_row,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    placed,
	output logic      [1:0]         rotation,
	output logic      [5:0]         top_row,
	output logic      [5:0]         left_col,
	output logic      [12:0]        occupied_count
);

	localparam int JW = 2 * DIM_W + SHAPE_MAX * ROW_W;

	logic [CFG_W-1:0] board_rows_q, board_cols_q;
	logic [CFG_W-1:0] br, bc;
	logic             take, push, q_full, q_not_empty, pop;
	logic [JW-1:0]    push_data, head_data;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_rows_q <= BOARD_DIM_RESET;
			board_cols_q <= BOARD_DIM_RESET;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_BOARD_ROWS: board_rows_q <= cfg_wdata;
				REG_BOARD_COLS: board_cols_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		br = (board_rows_q > CFG_W'(BOARD_MAX)) ? CFG_W'(BOARD_MAX) : board_rows_q;
		bc = (board_cols_q > CFG_W'(BOARD_MAX)) ? CFG_W'(BOARD_MAX) : board_cols_q;
	end

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	ffsp_front #(
		.SHAPE_MAX(SHAPE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.shape_rows(shape_rows),
		.shape_cols(shape_cols),
		.row_mask  (row_mask),
		.last_row  (last_row),
		.push      (push),
		.push_data (push_data)
	);

	ffsp_queue #(
		.WIDTH(JW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head_data(head_data)
	);

	ffsp_back #(
		.BOARD_MAX(BOARD_MAX),
		.SHAPE_MAX(SHAPE_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.br       (br),
		.bc       (bc),
		.job_valid(q_not_empty),
		.job_data (head_data),
		.job_pop  (pop),
		.res_valid(out_valid),
		.res_stall(out_stall),
		.res      (res)
	);

	assign placed         = res.placed;
	assign rotation       = res.rotation;
	assign top_row        = res.top_row;
	assign left_col       = res.left_col;
	assign occupied_count = res.occupied_count;

endmodule
`default_nettype wire
